// ===== rtl/core/tbd_pkg.sv =====
// Shared types and constants for the timed button debounce block.
package tbd_pkg;

  // Event codes reported with every result beat.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } evt_t;

  localparam int unsigned DEBOUNCE_BITS = 16;
  localparam int unsigned STAMP_BITS    = 32;
  localparam int unsigned HOLD_BITS     = 32;

  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd20;

endpackage

// ===== rtl/core/timed_button_debounce.sv =====
// Time-based debouncer for one push button, with press and release events and hold timing.
//
// Usage:
//   Input stream s_*: one beat per sample of the raw pin level together with the
//   millisecond timestamp at which it was taken.
//   Output stream m_*: exactly one result beat per input beat, in order, carrying
//   the event code, the ready flag, the debounced state, the current hold time and
//   the length of the last completed press.
//   cfg_we / cfg_data write the debounce window in milliseconds; write it only
//   while no sample is in flight.
// Timing:
//   A result appears in the cycle after its sample is accepted. While m_tready is
//   high a new sample can be taken in every cycle, so the block sustains one beat per
//   cycle; the single result register is the only stage, and it is refilled in the
//   same cycle that the receiver takes its contents.
// Reset (rst, synchronous, active high) empties the result register, sets the
//   window to 20 ms and returns the debouncer to the released, not-ready state.
// Stall: while m_tready is low and a result waits, s_tready is low and the sample
//   is held upstream; no beat is lost or repeated.
// Timestamp differences wrap modulo 2^TIME_BITS.
module timed_button_debounce #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] pin_high, [32:1] now_ms, [39:33] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [1:0] event_res, [2] ready_res, [3] is_pressed,
                                 // [35:4] hold_now_ms, [67:36] last_hold_ms, [71:68] zero
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import tbd_pkg::*;

  typedef logic [TIME_BITS-1:0] stamp_t;

  // Configuration and debouncer state.
  logic [DEBOUNCE_BITS-1:0] debounce_ms;
  logic   last_raw_high, last_raw_high_next;
  stamp_t raw_change_time, raw_change_time_next;
  logic   stable_high, stable_high_next;
  stamp_t stable_time, stable_time_next;
  logic   confirmed_once, confirmed_once_next;
  stamp_t press_length, press_length_next;

  // Result register.
  evt_t                 res_event, res_event_next;
  logic                 res_ready;
  logic                 res_pressed, res_pressed_next;
  logic [HOLD_BITS-1:0] res_hold, res_hold_next;
  logic [HOLD_BITS-1:0] res_last, res_last_next;

  logic                  pin_high;
  logic [STAMP_BITS-1:0] now_ms;
  logic [63:0]           now_wide;
  stamp_t                now_t;
  stamp_t                raw_elapsed;
  stamp_t                hold_elapsed;
  logic                  accept;

  assign pin_high = s_tdata[0];
  assign now_ms   = s_tdata[32:1];
  // The timestamp is zero-extended or cut down to the internal time width.
  assign now_wide = {32'd0, now_ms};
  assign now_t    = now_wide[TIME_BITS-1:0];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign raw_elapsed = now_t - raw_change_time;

  always_comb begin
    last_raw_high_next   = last_raw_high;
    raw_change_time_next = raw_change_time;
    stable_high_next     = stable_high;
    stable_time_next     = stable_time;
    confirmed_once_next  = confirmed_once;
    press_length_next    = press_length;
    res_event_next       = EV_NONE;
    if (pin_high != last_raw_high) begin
      // A change of level restarts the stability window.
      last_raw_high_next   = pin_high;
      raw_change_time_next = now_t;
    end else if (raw_elapsed >= TIME_BITS'(debounce_ms)) begin
      if (!confirmed_once) begin
        // The first confirmed level only makes the debouncer ready.
        stable_high_next    = pin_high;
        stable_time_next    = now_t;
        confirmed_once_next = 1'b1;
      end else if (pin_high != stable_high) begin
        stable_high_next = pin_high;
        stable_time_next = now_t;
        if (pin_high) begin
          press_length_next = now_t - stable_time;
          res_event_next    = EV_UP;
        end else begin
          res_event_next = EV_DOWN;
        end
      end
    end
  end

  assign hold_elapsed = now_t - stable_time_next;

  always_comb begin
    logic [63:0] hold_wide;
    logic [63:0] last_wide;
    hold_wide        = 64'(hold_elapsed);
    last_wide        = 64'(press_length_next);
    res_pressed_next = !stable_high_next;
    res_hold_next    = res_pressed_next ? hold_wide[HOLD_BITS-1:0] : '0;
    res_last_next    = last_wide[HOLD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RESET;
      last_raw_high   <= 1'b1;
      raw_change_time <= '0;
      stable_high     <= 1'b1;
      stable_time     <= '0;
      confirmed_once  <= 1'b0;
      press_length    <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        debounce_ms <= cfg_data;
      end
      if (accept) begin
        last_raw_high   <= last_raw_high_next;
        raw_change_time <= raw_change_time_next;
        stable_high     <= stable_high_next;
        stable_time     <= stable_time_next;
        confirmed_once  <= confirmed_once_next;
        press_length    <= press_length_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_event   <= res_event_next;
      res_ready   <= confirmed_once_next;
      res_pressed <= res_pressed_next;
      res_hold    <= res_hold_next;
      res_last    <= res_last_next;
    end
  end

  assign m_tdata = {4'd0, res_last, res_hold, res_pressed, res_ready, res_event};

`ifndef NO_ASSERTIONS
  // A press or release event is only ever reported once the debouncer is ready.
  a_event_needs_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_event != EV_NONE) |-> res_ready)
    else $error("event reported before the debouncer was ready");

  // A press event leaves the button pressed, a release event leaves it released.
  a_event_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res_event == EV_DOWN) ? res_pressed :
                  (res_event == EV_UP) ? !res_pressed : 1'b1))
    else $error("event code disagrees with the debounced state");

  // The hold time is zero whenever the button is released.
  a_hold_zero_released: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_pressed) |-> (res_hold == '0))
    else $error("hold time reported while released");

  // Every accepted sample yields a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted sample produced no result beat");

  // The debounced state cannot leave the released level before the first confirmation.
  a_released_until_ready: assert property (@(posedge clk) disable iff (rst)
    !confirmed_once |-> stable_high)
    else $error("debounced state changed before ready");
`endif

endmodule

// ===== tb/sv/timed_button_debounce_tb.sv =====
// Self-checking testbench for the timed button debounce block.
`timescale 1ns / 100ps

module timed_button_debounce_tb;
  import tbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_MISMATCH  = 40;
  localparam int unsigned PHASE_SAMPLES = 245;

  typedef struct packed {
    evt_t        ev;
    logic        rdy;
    logic        pressed;
    logic [31:0] hold_now;
    logic [31:0] last_hold;
  } button_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [0] pin_high, [32:1] now_ms, [39:33] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [1:0] event_res, [2] ready_res, [3] is_pressed,
                          // [35:4] hold_now_ms, [67:36] last_hold_ms, [71:68] zero
  logic        cfg_we;
  logic [15:0] cfg_data;

  // Debouncer state as the block should hold it.
  logic        raw_lvl     = 1'b1;
  logic [31:0] raw_since   = '0;
  logic        stab_lvl    = 1'b1;
  logic [31:0] stab_since  = '0;
  logic        armed       = 1'b0;
  logic [31:0] press_len   = '0;
  logic [15:0] window_ms   = DEBOUNCE_RESET;

  button_result_t pending_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    rx_wait = 0;
  int unsigned    hold_left = 0;
  bit             tx_idle = 1'b1;
  bit             rx_idle = 1'b1;

  timed_button_debounce dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic button_result_t step_debouncer(logic lvl, logic [31:0] stamp);
    button_result_t r;
    logic [31:0]    since_change;
    r.ev = EV_NONE;
    since_change = stamp - raw_since;
    if (lvl != raw_lvl) begin
      // A new raw level only restarts the window; it cannot confirm itself.
      raw_lvl = lvl;
      raw_since = stamp;
    end else if (since_change >= {16'd0, window_ms}) begin
      if (!armed) begin
        stab_lvl = lvl;
        stab_since = stamp;
        armed = 1'b1;
      end else if (lvl != stab_lvl) begin
        if (lvl) begin
          press_len = stamp - stab_since;
          r.ev = EV_UP;
        end else begin
          r.ev = EV_DOWN;
        end
        stab_lvl = lvl;
        stab_since = stamp;
      end
    end
    r.rdy = armed;
    r.pressed = !stab_lvl;
    r.hold_now = stab_lvl ? 32'd0 : stamp - stab_since;
    r.last_hold = press_len;
    return r;
  endfunction

  task automatic report_field(string field, logic [71:0] want, logic [71:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_MISMATCH)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  task automatic check_result();
    button_result_t want;
    if (pending_results.size() == 0) begin
      report_field("unexpected beat, tdata", 72'd0, m_tdata);
      return;
    end
    want = pending_results.pop_front();
    if (m_tdata[1:0] != want.ev)
      report_field("event_res", 72'(want.ev), 72'(m_tdata[1:0]));
    if (m_tdata[2] != want.rdy)
      report_field("ready_res", 72'(want.rdy), 72'(m_tdata[2]));
    if (m_tdata[3] != want.pressed)
      report_field("is_pressed", 72'(want.pressed), 72'(m_tdata[3]));
    if (m_tdata[35:4] != want.hold_now)
      report_field("hold_now_ms", 72'(want.hold_now), 72'(m_tdata[35:4]));
    if (m_tdata[67:36] != want.last_hold)
      report_field("last_hold_ms", 72'(want.last_hold), 72'(m_tdata[67:36]));
  endtask

  // Receiver: takes result beats, stalls at random and honours a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
        rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Returns in the time step of the accepting edge, so the caller may keep tvalid high.
  task automatic send_sample(logic lvl, logic [31:0] stamp);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, stamp, lvl};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    pending_results.push_back(step_debouncer(lvl, stamp));
  endtask

  task automatic drop_valid();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] value);
    drop_valid();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ms = value;
  endtask

  // Fresh state under the reset window: the first confirmed level is the pressed one.
  task automatic test_first_confirm_pressed();
    send_sample(1'b0, 32'd0);
    send_sample(1'b0, 32'd19);
    send_sample(1'b0, 32'd25);
    send_sample(1'b0, 32'd30);
    send_sample(1'b1, 32'd40);
    send_sample(1'b1, 32'd60);
    send_sample(1'b0, 32'd61);
    send_sample(1'b0, 32'd81);
  endtask

  // Timestamps that wrap through zero and timestamps that run backwards.
  task automatic test_wrap_and_order();
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_0004);
    send_sample(1'b0, 32'h0000_0200);
    send_sample(1'b0, 32'h0000_0100);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0010);
    send_sample(1'b1, 32'h0000_0024);
  endtask

  // With no window a level is confirmed on its second equal sample.
  task automatic test_zero_window();
    write_window(16'd0);
    send_sample(1'b0, 32'd5);
    send_sample(1'b0, 32'd5);
    send_sample(1'b1, 32'd5);
    send_sample(1'b1, 32'd5);
  endtask

  task automatic test_widest_window();
    write_window(16'hFFFF);
    send_sample(1'b0, 32'h0000_1000);
    send_sample(1'b0, 32'h0001_0FFE);
    send_sample(1'b0, 32'h0001_0FFF);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b1, 32'h8001_0000);
  endtask

  // The receiver holds off while samples keep coming, so the block must stall its input.
  task automatic test_backpressure();
    logic [31:0] stamp;
    write_window(16'd3);
    tx_idle = 1'b0;
    stamp = $urandom;
    hold_left = 300;
    repeat (40) begin
      stamp = stamp + $urandom_range(0, 4);
      send_sample(stamp[3], stamp);
    end
    tx_idle = 1'b1;
  endtask

  // Bouncy presses and releases with random timing, plus some arbitrary samples.
  task automatic test_random_gestures();
    logic [15:0] windows[7];
    logic [31:0] clock_ms;
    logic        lvl;
    int unsigned win;
    int unsigned sent;
    int unsigned bounces;
    windows = '{16'd0, 16'd1, 16'd20, 16'hFFFF, 16'd0, 16'd5, 16'd0};
    windows[4] = 16'($urandom_range(2, 300));
    windows[6] = 16'($urandom);
    for (int p = 0; p < 7; p++) begin
      write_window(windows[p]);
      win = 32'(windows[p]);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      clock_ms = $urandom;
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        if ($urandom_range(0, 9) == 0) begin
          send_sample(1'($urandom_range(0, 1)), $urandom);
          sent++;
        end else begin
          lvl = 1'($urandom_range(0, 1));
          bounces = $urandom_range(0, 4);
          for (int b = 0; b < bounces; b++) begin
            clock_ms = clock_ms + $urandom_range(0, win / 2);
            send_sample((b % 2 == 0) ? !lvl : lvl, clock_ms);
            sent++;
          end
          // Enough settled samples to cover the whole window.
          repeat ($urandom_range(3, 6)) begin
            clock_ms = clock_ms + $urandom_range(win / 3 + 1, win / 2 + 3);
            send_sample(lvl, clock_ms);
            sent++;
          end
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_first_confirm_pressed();
    test_wrap_and_order();
    test_zero_window();
    test_widest_window();
    test_backpressure();
    test_random_gestures();
    drop_valid();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tbd_pkg.sv
rtl/core/timed_button_debounce.sv
tb/sv/timed_button_debounce_tb.sv
